FILE: rtl/core/ptd_pkg.sv
// shared types and constants of the point to depth image projector
package ptd_pkg;

    localparam int PW  = 20;
    localparam int FW  = 18;
    localparam int DW  = 16;
    localparam int RCW = 10;
    localparam int RRW = 9;
    localparam int CIW = 3;
    localparam int QDEPTH = 2;

    localparam logic [CIW-1:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [CIW-1:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [CIW-1:0] CFG_CENTER_X = 3'd2;
    localparam logic [CIW-1:0] CFG_CENTER_Y = 3'd3;
    localparam logic [CIW-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CIW-1:0] CFG_HEIGHT   = 3'd5;

    typedef enum logic [1:0] {
        K_READ,
        K_PROJ,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic signed [PW-1:0]  x;
        logic signed [PW-1:0]  y;
        logic signed [PW-1:0]  z;
        logic [DW-1:0]         depth;
        logic [RCW-1:0]        rcol;
        logic [RRW-1:0]        rrow;
    } t_item;

    typedef struct packed {
        logic [FW-1:0] fx;
        logic [FW-1:0] fy;
        logic [FW-1:0] cx;
        logic [FW-1:0] cy;
    } t_optics;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SUM,
        S_PREP,
        S_DIV,
        S_CLAMP,
        S_ADDR,
        S_RREQ,
        S_RDATA,
        S_WRITE
    } t_state;

endpackage

FILE: rtl/core/ptd_front.sv
// front end: accepts items, drops skipped points, classifies and saturates depth
module ptd_front import ptd_pkg::*; (
    input  logic                 start,
    input  logic                 i_busy,
    input  logic                 i_operation,
    input  logic signed [PW-1:0] i_point_x_mm,
    input  logic signed [PW-1:0] i_point_y_mm,
    input  logic signed [PW-1:0] i_point_z_mm,
    input  logic                 i_z_is_number,
    input  logic [RCW-1:0]       i_read_col,
    input  logic [RRW-1:0]       i_read_row,
    output logic                 o_push,
    output t_item                o_item
);

    always_comb begin
        o_push = start && !i_busy && (i_operation || i_z_is_number);
        o_item.x    = i_point_x_mm;
        o_item.y    = i_point_y_mm;
        o_item.z    = i_point_z_mm;
        o_item.rcol = i_read_col;
        o_item.rrow = i_read_row;
        if (i_operation) begin
            o_item.kind = K_READ;
        end else if (i_point_z_mm == '0) begin
            o_item.kind = K_ZERO;
        end else begin
            o_item.kind = K_PROJ;
        end
        if (i_point_z_mm[PW-1]) begin
            o_item.depth = '0;
        end else if (i_point_z_mm > $signed(PW'(65535))) begin
            o_item.depth = '1;
        end else begin
            o_item.depth = i_point_z_mm[DW-1:0];
        end
    end

endmodule

FILE: rtl/core/ptd_queue.sv
// two-entry item queue between front and back
module ptd_queue import ptd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int QAW = $clog2(QDEPTH);

    t_item             r_mem [QDEPTH];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QAW:0]      r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: rtl/core/ptd_back.sv
// back end: projection, iterative divide, clamping and the depth image memory
module ptd_back import ptd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  t_item                               i_item,
    output logic                                o_pop,
    input  t_optics                             i_optics,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_col_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0]       i_row_last,
    output logic                                o_clearing,
    output logic                                o_done,
    output logic [DW-1:0]                       o_depth_value
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int QW    = (CW > RW) ? CW : RW;
    localparam int CNW   = $clog2(QW);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADW   = $clog2(DEPTH);
    localparam int MW    = PW + FW + 1;
    localparam int SW    = MW + 1;
    localparam int AW    = SW - 8;
    localparam int ZW    = PW;

    t_state               r_state;
    t_state               n_state;
    t_item                r_item;
    logic                 r_inrange;
    logic signed [MW-1:0] r_pfx;
    logic signed [MW-1:0] r_czx;
    logic signed [MW-1:0] r_pfy;
    logic signed [MW-1:0] r_czy;
    logic [AW-1:0]        r_ax;
    logic [AW-1:0]        r_ay;
    logic [ZW-1:0]        r_bz;
    logic                 r_satx;
    logic                 r_saty;
    logic [ZW-1:0]        r_remx;
    logic [ZW-1:0]        r_remy;
    logic [QW-1:0]        r_lx;
    logic [QW-1:0]        r_ly;
    logic [CNW-1:0]       r_cnt;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [ADW-1:0]       r_addr;
    logic [DW-1:0]        r_rdata;
    logic                 r_done;
    logic [DW-1:0]        r_dout;
    logic [DW-1:0]        r_mem [DEPTH];

    logic                 mem_we;
    logic [DW-1:0]        mem_wdata;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic [SW-1:0]        mag_x;
    logic [SW-1:0]        mag_y;
    logic [ZW:0]          rem2_x;
    logic [ZW:0]          rem2_y;
    logic                 ge_x;
    logic                 ge_y;

    assign o_clearing    = (r_state == S_CLEAR);
    assign o_done        = r_done;
    assign o_depth_value = r_dout;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == ADW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_item.kind == K_PROJ) ? S_MUL : S_ADDR;
                end
            end
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: n_state = S_ADDR;
            S_ADDR: begin
                if (r_item.kind == K_READ) begin
                    n_state = r_inrange ? S_RREQ : S_IDLE;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_RREQ:  n_state = S_RDATA;
            S_RDATA: n_state = S_IDLE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == S_IDLE) && !i_empty;
        mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE) || (r_state == S_RDATA);
        mem_wdata = (r_state == S_WRITE) ? r_item.depth : '0;
    end

    always_comb begin
        sum_x  = SW'(r_pfx) + SW'(r_czx);
        sum_y  = SW'(r_pfy) + SW'(r_czy);
        mag_x  = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
        mag_y  = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
        rem2_x = {r_remx, r_lx[QW-1]};
        rem2_y = {r_remy, r_ly[QW-1]};
        ge_x   = rem2_x >= {1'b0, r_bz};
        ge_y   = rem2_y >= {1'b0, r_bz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (r_state == S_CLEAR) begin
                r_addr <= r_addr + 1'b1;
            end else if (r_state == S_ADDR) begin
                r_addr <= ADW'(32'(r_row) * MAX_WIDTH + 32'(r_col));
            end
            if ((r_state == S_ADDR && r_item.kind == K_READ && !r_inrange)
                || r_state == S_RDATA) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item    <= i_item;
                r_inrange <= (32'(i_item.rcol) <= 32'(i_col_last))
                          && (32'(i_item.rrow) <= 32'(i_row_last));
                if (i_item.kind == K_READ) begin
                    r_col <= CW'(i_item.rcol);
                    r_row <= RW'(i_item.rrow);
                end else begin
                    r_col <= '0;
                    r_row <= '0;
                end
            end
            S_MUL: begin
                r_pfx <= r_item.x * $signed({1'b0, i_optics.fx});
                r_czx <= r_item.z * $signed({1'b0, i_optics.cx});
                r_pfy <= r_item.y * $signed({1'b0, i_optics.fy});
                r_czy <= r_item.z * $signed({1'b0, i_optics.cy});
                r_bz  <= r_item.z[PW-1] ? ZW'(-r_item.z) : ZW'(r_item.z);
            end
            S_SUM: begin
                r_ax <= mag_x[SW-1:8];
                r_ay <= mag_y[SW-1:8];
            end
            S_PREP: begin
                r_satx <= (r_ax >> QW) >= AW'(r_bz);
                r_saty <= (r_ay >> QW) >= AW'(r_bz);
                r_remx <= ZW'(r_ax >> QW);
                r_remy <= ZW'(r_ay >> QW);
                r_lx   <= r_ax[QW-1:0];
                r_ly   <= r_ay[QW-1:0];
                r_cnt  <= CNW'(QW - 1);
            end
            S_DIV: begin
                r_remx <= ge_x ? ZW'(rem2_x - {1'b0, r_bz}) : ZW'(rem2_x);
                r_remy <= ge_y ? ZW'(rem2_y - {1'b0, r_bz}) : ZW'(rem2_y);
                r_lx   <= {r_lx[QW-2:0], ge_x};
                r_ly   <= {r_ly[QW-2:0], ge_y};
                r_cnt  <= r_cnt - 1'b1;
            end
            S_CLAMP: begin
                r_col <= (r_satx || r_lx > QW'(i_col_last)) ? i_col_last : CW'(r_lx);
                r_row <= (r_saty || r_ly > QW'(i_row_last)) ? i_row_last : RW'(r_ly);
            end
            S_ADDR: begin
                r_dout <= '0;
            end
            S_RDATA: begin
                r_dout <= r_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_addr];
    end

endmodule

FILE: rtl/core/point_to_depth_image_projector_core.sv
// top level of the point to depth image projector
// Usage:
// - an item is taken when start is high and busy is low; operation 0 projects a
//   point and stores its saturated depth, operation 1 reads a pixel and clears it
// - a read gives one result: o_done is high for one cycle with o_depth_value
// - projections and skipped points give no result
// - configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at once
// - flow: a projection passes the multiply, sum, prepare, divide, clamp, address and
//   write states of the back end, the divide state running a one-bit-per-cycle
//   restoring divider; a taken read passes the queue and the idle, address, request
//   and data states before o_done rises (idle and address only for outside pixels)
// - a two-item queue lets the front take items while the back end works
// - reset clears all MAX_WIDTH*MAX_HEIGHT memory entries in one pass, one entry per
//   cycle; busy stays high meanwhile, configuration writes are still taken
// - results cannot be held off by the receiver
module point_to_depth_image_projector_core import ptd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_operation,
    input  logic signed [PW-1:0] i_point_x_mm,
    input  logic signed [PW-1:0] i_point_y_mm,
    input  logic signed [PW-1:0] i_point_z_mm,
    input  logic                 i_z_is_number,
    input  logic [RCW-1:0]       i_read_col,
    input  logic [RRW-1:0]       i_read_row,
    input  logic                 i_cfg_we,
    input  logic [CIW-1:0]       i_cfg_index,
    input  logic [FW-1:0]        i_cfg_data,
    output logic                 o_done,
    output logic [DW-1:0]        o_depth_value
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    t_optics        r_optics;
    logic [10:0]    r_width;
    logic [9:0]     r_height;
    logic [CW-1:0]  col_last;
    logic [RW-1:0]  row_last;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    logic           clearing;
    t_item          front_item;
    t_item          q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_optics.fx <= FW'(117910);
            r_optics.fy <= FW'(117829);
            r_optics.cx <= FW'(85524);
            r_optics.cy <= FW'(43471);
            r_width     <= 11'd640;
            r_height    <= 10'd360;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOCAL_X:  r_optics.fx <= i_cfg_data;
                CFG_FOCAL_Y:  r_optics.fy <= i_cfg_data;
                CFG_CENTER_X: r_optics.cx <= i_cfg_data;
                CFG_CENTER_Y: r_optics.cy <= i_cfg_data;
                CFG_WIDTH:    r_width     <= i_cfg_data[10:0];
                CFG_HEIGHT:   r_height    <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            col_last = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            col_last = CW'(MAX_WIDTH - 1);
        end else begin
            col_last = CW'(r_width - 11'd1);
        end
        if (r_height == '0) begin
            row_last = '0;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            row_last = RW'(MAX_HEIGHT - 1);
        end else begin
            row_last = RW'(r_height - 10'd1);
        end
    end

    assign busy = q_full || clearing;

    ptd_front u_front (
        .start         (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_point_x_mm  (i_point_x_mm),
        .i_point_y_mm  (i_point_y_mm),
        .i_point_z_mm  (i_point_z_mm),
        .i_z_is_number (i_z_is_number),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .o_push        (push),
        .o_item        (front_item)
    );

    ptd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ptd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_item        (q_item),
        .o_pop         (pop),
        .i_optics      (r_optics),
        .i_col_last    (col_last),
        .i_row_last    (row_last),
        .o_clearing    (clearing),
        .o_done        (o_done),
        .o_depth_value (o_depth_value)
    );

endmodule

FILE: rtl/core/ptd_checker.sv
// port-level checker for the projector top level, with its bind
module ptd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");

    a_reset_busy: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> busy)
        else $error("busy low right after reset");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !(start && !busy))
        else $error("item taken during memory clear");

endmodule

bind point_to_depth_image_projector_core ptd_checker u_ptd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

FILE: test/tb_point_to_depth_image_projector_core.sv
// testbench of the point to depth image projector: random points and reads checked against a predictor
module tb_point_to_depth_image_projector_core;
    import ptd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 1024;
    localparam int MAXH = 512;
    localparam int IDLE_LIMIT = 2000000;

    class depth_scoreboard;
        logic [DW-1:0] pixels [int];
        logic [FW-1:0] fx, fy, cx, cy;
        logic [10:0]   width_reg;
        logic [9:0]    height_reg;
        logic [DW-1:0] pending_depths [$];
        int            mismatches;

        function void set_defaults();
            fx = 117910;
            fy = 117829;
            cx = 85524;
            cy = 43471;
            width_reg = 640;
            height_reg = 360;
        endfunction

        function void write_reg(logic [CIW-1:0] index, logic [FW-1:0] data);
            case (index)
                CFG_FOCAL_X:  fx = data;
                CFG_FOCAL_Y:  fy = data;
                CFG_CENTER_X: cx = data;
                CFG_CENTER_Y: cy = data;
                CFG_WIDTH:    width_reg = data[10:0];
                CFG_HEIGHT:   height_reg = data[9:0];
                default: ;
            endcase
        endfunction

        function longint active_dim(longint reg_value, longint maxv);
            if (reg_value == 0) return 1;
            if (reg_value > maxv) return maxv;
            return reg_value;
        endfunction

        function longint axis_pos(longint p, longint z, longint f, longint c, longint lim);
            longint pos;
            pos = (p * f + c * z) / (z * 256);
            if (pos > lim - 1) begin
                pos = lim - 1;
            end else if (pos < 0) begin
                pos = -pos;
                if (pos > lim - 1) pos = lim - 1;
            end
            return pos;
        endfunction

        function void note_item(logic op, logic signed [PW-1:0] x, logic signed [PW-1:0] y,
                                logic signed [PW-1:0] z, logic znum,
                                logic [RCW-1:0] rcol, logic [RRW-1:0] rrow);
            longint w, h, col, row, zz;
            logic [DW-1:0] d;
            int key;
            w = active_dim(width_reg, MAXW);
            h = active_dim(height_reg, MAXH);
            if (op) begin
                d = '0;
                if (rcol < w && rrow < h) begin
                    key = rrow * MAXW + rcol;
                    if (pixels.exists(key)) begin
                        d = pixels[key];
                        pixels.delete(key);
                    end
                end
                pending_depths.push_back(d);
            end else if (znum) begin
                zz = z;
                col = 0;
                row = 0;
                d = '0;
                if (zz != 0) begin
                    col = axis_pos(x, zz, fx, cx, w);
                    row = axis_pos(y, zz, fy, cy, h);
                    d = (zz < 0) ? 16'd0 : (zz > 65535) ? 16'hFFFF : zz[15:0];
                end
                pixels[int'(row * MAXW + col)] = d;
            end
        endfunction

        function void check_depth(logic [DW-1:0] actual);
            logic [DW-1:0] want;
            if (pending_depths.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result depth %0d", actual);
                return;
            end
            want = pending_depths.pop_front();
            if (want !== actual) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("depth mismatch: expected %0d actual %0d", want, actual);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_operation;
    logic signed [PW-1:0] i_point_x_mm;
    logic signed [PW-1:0] i_point_y_mm;
    logic signed [PW-1:0] i_point_z_mm;
    logic                 i_z_is_number;
    logic [RCW-1:0]       i_read_col;
    logic [RRW-1:0]       i_read_row;
    logic                 i_cfg_we;
    logic [CIW-1:0]       i_cfg_index;
    logic [FW-1:0]        i_cfg_data;
    logic                 o_done;
    logic [DW-1:0]        o_depth_value;

    depth_scoreboard board;
    int idle_cycles;
    int burst_left;

    point_to_depth_image_projector_core dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_depth(o_depth_value);
        if (i_rst_n && ((start && !busy) || o_done)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("point_to_depth_image_projector_core regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(logic [CIW-1:0] index, logic [FW-1:0] data);
        i_cfg_we <= 1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        board.write_reg(index, data);
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic op, logic signed [PW-1:0] x, logic signed [PW-1:0] y,
                             logic signed [PW-1:0] z, logic znum,
                             logic [RCW-1:0] rcol, logic [RRW-1:0] rrow);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                start <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1;
        i_operation <= op;
        i_point_x_mm <= x;
        i_point_y_mm <= y;
        i_point_z_mm <= z;
        i_z_is_number <= znum;
        i_read_col <= rcol;
        i_read_row <= rrow;
        do @(posedge i_clk); while (busy);
        board.note_item(op, x, y, z, znum, rcol, rrow);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (board.pending_depths.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic rand_point(int n_items, int wmax, int hmax);
        logic signed [PW-1:0] x, y, z;
        int sel;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                send_item(1, PW'($urandom), PW'($urandom), PW'($urandom), 1'($urandom),
                          RCW'($urandom_range(0, wmax)), RRW'($urandom_range(0, hmax)));
            end else begin
                z = (sel == 4) ? $signed(PW'($urandom))
                               : $signed(PW'($urandom_range(1, 70000)));
                if (sel == 5) z = 0;
                x = (sel == 6) ? $signed(PW'($urandom))
                               : $signed(PW'($urandom_range(0, 4000)) - PW'(2000));
                y = (sel == 6) ? $signed(PW'($urandom))
                               : $signed(PW'($urandom_range(0, 4000)) - PW'(2000));
                send_item(0, x, y, z, sel != 7 || $urandom_range(0, 1),
                          RCW'($urandom), RRW'($urandom));
            end
        end
    endtask

    initial begin
        board = new();
        board.set_defaults();
        idle_cycles = 0;
        burst_left = 0;
        i_rst_n = 0;
        start = 0;
        i_operation = 0;
        i_point_x_mm = 0;
        i_point_y_mm = 0;
        i_point_z_mm = 0;
        i_z_is_number = 0;
        i_read_col = 0;
        i_read_row = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_FOCAL_X;
        i_cfg_data = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes and special cases at reset settings
        send_item(0, 100, 50, 1000, 1, 0, 0);
        send_item(0, 0, 0, 0, 1, 0, 0);
        send_item(0, 7, 7, 2000, 0, 0, 0);
        send_item(0, 20'sh7FFFF, 20'sh7FFFF, 1, 1, 0, 0);
        send_item(0, 20'sh80000, 20'sh80000, 1, 1, 0, 0);
        send_item(0, 20'sh80000, 20'sh7FFFF, 20'sh80000, 1, 0, 0);
        send_item(0, -300, -200, 500, 1, 0, 0);
        send_item(0, 10, 10, 20'sh7FFFF, 1, 0, 0);
        send_item(0, -5, 9, -700, 1, 0, 0);
        send_item(1, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 1, 1023, 511);
        send_item(1, 0, 0, 0, 0, 639, 359);
        send_item(1, 0, 0, 0, 0, 640, 0);
        send_item(1, 0, 0, 0, 0, 0, 360);
        send_item(1, 0, 0, 0, 0, 0, 0);
        send_item(1, 0, 0, 0, 0, 0, 0);
        send_item(1, 0, 0, 0, 0, 639, 0);
        send_item(1, 0, 0, 0, 0, 0, 359);
        send_item(1, 0, 0, 0, 0, 639, 359);
        drain();

        rand_point(400, 700, 400);
        drain();

        // small image, extreme optics
        cfg_write(CFG_WIDTH, 4);
        cfg_write(CFG_HEIGHT, 3);
        cfg_write(CFG_FOCAL_X, 18'h3FFFF);
        cfg_write(CFG_FOCAL_Y, 0);
        cfg_write(CFG_CENTER_X, 0);
        cfg_write(CFG_CENTER_Y, 18'h3FFFF);
        rand_point(300, 7, 5);
        drain();

        // zero dimensions treated as one, then oversized ones
        cfg_write(CFG_WIDTH, 0);
        cfg_write(CFG_HEIGHT, 0);
        cfg_write(CFG_FOCAL_X, 256);
        cfg_write(CFG_FOCAL_Y, 256);
        rand_point(100, 2, 2);
        drain();
        cfg_write(CFG_WIDTH, 11'h7FF);
        cfg_write(CFG_HEIGHT, 10'h3FF);
        cfg_write(CFG_CENTER_X, 512 * 256);
        cfg_write(CFG_CENTER_Y, 256 * 256);
        rand_point(350, 1023, 511);
        drain();

        // maximum legal dimensions with random optics
        cfg_write(CFG_WIDTH, 1024);
        cfg_write(CFG_HEIGHT, 512);
        cfg_write(CFG_FOCAL_X, FW'($urandom));
        cfg_write(CFG_FOCAL_Y, FW'($urandom));
        cfg_write(CFG_CENTER_X, FW'($urandom));
        cfg_write(CFG_CENTER_Y, FW'($urandom));
        rand_point(350, 1023, 511);
        drain();

        if (board.mismatches == 0 && board.pending_depths.size() == 0)
            $display("point_to_depth_image_projector_core regression: pass");
        else
            $display("point_to_depth_image_projector_core regression: fail");
        $finish;
    end
endmodule
